FILE: src/cbm_pkg.sv
// ---------------------------------------------------------------------------
// cbm_pkg
// shared widths, codes and types for the cube map bilinear address block
// ---------------------------------------------------------------------------
package cbm_pkg;

	// default parameter values
	localparam int DIR_BITS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 8;

	// largest face is 1 << MAX_SIZE_LOG2 texels
	localparam int MAX_SIZE_LOG2 = 11;
	localparam int TEX_W         = MAX_SIZE_LOG2;

	// u,v in [0,1] with 16 fraction bits, so 17 bits to hold 1.0
	localparam int UNIT_FRAC = 16;
	localparam int UNIT_W    = UNIT_FRAC + 1;

	localparam int FACE_W  = 3;
	localparam int MIP_W   = 4;
	localparam int FSIZE_W = 12;
	localparam int MCNT_W  = 4;

	// configuration port
	localparam int CFG_W     = FSIZE_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FACE_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIP_COUNT = 1'd1;

	localparam logic [FSIZE_W-1:0] FSIZE_RST  = 12'd256;
	localparam logic [MCNT_W-1:0]  MCNT_RST   = 4'd1;
	localparam logic [FSIZE_W-1:0] SIZE_LIMIT = FSIZE_W'(1 << MAX_SIZE_LOG2);

	// face codes
	localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
	localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

	// per-word side information that rides along the divider
	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic [MIP_W-1:0]  mip;
		logic [TEX_W-1:0]  szm1;
		logic              nos;
	} side_t;

endpackage

FILE: src/cubemap_bilinear_address_top.sv
// ---------------------------------------------------------------------------
// cubemap_bilinear_address_top
// cube map face selection and bilinear texel address generation
// ---------------------------------------------------------------------------
// Takes one direction word per clock and returns one address word per clock,
// in order, when the output side is not stalled.
// The pipe has 2 front stages (magnitudes, then face pick and numerator),
// 17 divider stages (a restoring divider that settles one of the 17 quotient
// bits of u and v per stage) and 2 back stages (scale by mip size minus one,
// then edge clamp and fraction extract). Every stage has its own valid bit and
// holds on a stall without blocking the stages in front of it, so bubbles
// close up and in_ready stays high while the pipe has room even when a result
// waits at the output. face_size and mip_count are written through the cfg
// port and should only change while no word is in flight.
// ---------------------------------------------------------------------------
module cubemap_bilinear_address_top #(
	parameter int DIR_BITS  = cbm_pkg::DIR_BITS_DEF,
	parameter int FRAC_BITS = cbm_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbm_pkg::CFG_W-1:0]        cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [DIR_BITS-1:0]       dir_x,
	input  logic signed [DIR_BITS-1:0]       dir_y,
	input  logic signed [DIR_BITS-1:0]       dir_z,
	input  logic [cbm_pkg::MIP_W-1:0]        mip_level,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cbm_pkg::FACE_W-1:0]       face,
	output logic [cbm_pkg::MIP_W-1:0]        mip_used,
	output logic [cbm_pkg::TEX_W-1:0]        texel_x0,
	output logic [cbm_pkg::TEX_W-1:0]        texel_y0,
	output logic [cbm_pkg::TEX_W-1:0]        texel_x1,
	output logic [cbm_pkg::TEX_W-1:0]        texel_y1,
	output logic [FRAC_BITS-1:0]             frac_x,
	output logic [FRAC_BITS-1:0]             frac_y,
	output logic                             no_sample
);
	import cbm_pkg::*;

	localparam int DW = DIR_BITS + 1;        // numerator and divisor width
	localparam int PW = UNIT_W + TEX_W;      // product width
	localparam int AW = PW - UNIT_FRAC;      // integer part of the product

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [FSIZE_W-1:0] face_size_q;
	logic [MCNT_W-1:0]  mip_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= FSIZE_RST;
			mip_count_q <= MCNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FACE_SIZE: face_size_q <= cfg_data[FSIZE_W-1:0];
				REG_MIP_COUNT: mip_count_q <= cfg_data[MCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage handshakes: each stage takes a word when empty or draining
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic take1, take2, take3, take4;
	logic div_in_ready;
	logic div_out_valid;

	assign take4    = !v_s4 || out_ready;
	assign take3    = !v_s3 || take4;
	assign take2    = !v_s2 || div_in_ready;
	assign take1    = !v_s1 || take2;
	assign in_ready = take1;

	// ------------------------------------------------------------------
	// stage 1: component magnitudes, mip clamp and mip size
	// ------------------------------------------------------------------
	logic [DIR_BITS-1:0] ux_c, uy_c, uz_c;
	logic [DIR_BITS-1:0] ax_c, ay_c, az_c;
	logic [MIP_W-1:0]    mip_top_c, mip_c;
	logic [FSIZE_W-1:0]  fs_lim_c, size_c;
	logic [TEX_W-1:0]    szm1_c;
	logic                nos_c;

	always_comb begin
		ux_c = dir_x;
		uy_c = dir_y;
		uz_c = dir_z;
		// magnitude of the most negative value comes out exact as unsigned
		ax_c = ux_c[DIR_BITS-1] ? (~ux_c + 1'b1) : ux_c;
		ay_c = uy_c[DIR_BITS-1] ? (~uy_c + 1'b1) : uy_c;
		az_c = uz_c[DIR_BITS-1] ? (~uz_c + 1'b1) : uz_c;

		// empty mip count acts as one level
		mip_top_c = (mip_count_q == '0) ? '0 : (mip_count_q - 1'b1);
		mip_c     = (mip_level < mip_top_c) ? mip_level : mip_top_c;

		// oversized faces saturate, tiny mips stay at one texel
		fs_lim_c = (face_size_q > SIZE_LIMIT) ? SIZE_LIMIT : face_size_q;
		size_c   = fs_lim_c >> mip_c;
		szm1_c   = (size_c == '0) ? '0 : TEX_W'(size_c - 1'b1);

		nos_c = (face_size_q == '0) || ((ux_c == '0) && (uy_c == '0) && (uz_c == '0));
	end

	logic [DIR_BITS-1:0] x_s1, y_s1, z_s1;
	logic [DIR_BITS-1:0] ax_s1, ay_s1, az_s1;
	logic [MIP_W-1:0]    mip_s1;
	logic [TEX_W-1:0]    szm1_s1;
	logic                nos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take1 && in_valid) begin
			x_s1    <= ux_c;
			y_s1    <= uy_c;
			z_s1    <= uz_c;
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			az_s1   <= az_c;
			mip_s1  <= mip_c;
			szm1_s1 <= szm1_c;
			nos_s1  <= nos_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: face pick, minor numerators, shifted to n + m over 2m
	// ------------------------------------------------------------------
	logic [DW-1:0]       ex_c, ey_c, ez_c;   // sign extended components
	logic [DW-1:0]       nx_c, ny_c, nz_c;   // their negations
	logic [DW-1:0]       nu_c, nv_c;
	logic [DIR_BITS-1:0] m_c;
	logic [FACE_W-1:0]   face_c;
	logic [DW:0]         su_c, sv_c;
	side_t               side_c;

	always_comb begin
		ex_c = {x_s1[DIR_BITS-1], x_s1};
		ey_c = {y_s1[DIR_BITS-1], y_s1};
		ez_c = {z_s1[DIR_BITS-1], z_s1};
		nx_c = ~ex_c + 1'b1;
		ny_c = ~ey_c + 1'b1;
		nz_c = ~ez_c + 1'b1;

		// ties go to x, then y; a zero major component counts as positive
		priority if (ax_s1 >= ay_s1 && ax_s1 >= az_s1) begin
			m_c = ax_s1;
			nv_c = ny_c;
			if (!x_s1[DIR_BITS-1]) begin
				face_c = FACE_PX;
				nu_c   = nz_c;
			end else begin
				face_c = FACE_NX;
				nu_c   = ez_c;
			end
		end else if (ay_s1 >= az_s1) begin
			m_c  = ay_s1;
			nu_c = ex_c;
			if (!y_s1[DIR_BITS-1]) begin
				face_c = FACE_PY;
				nv_c   = ez_c;
			end else begin
				face_c = FACE_NY;
				nv_c   = nz_c;
			end
		end else begin
			m_c  = az_s1;
			nv_c = ny_c;
			if (!z_s1[DIR_BITS-1]) begin
				face_c = FACE_PZ;
				nu_c   = ex_c;
			end else begin
				face_c = FACE_NZ;
				nu_c   = nx_c;
			end
		end

		// n + m lies in [0, 2m], so its low DW bits are exact
		su_c = {nu_c[DW-1], nu_c} + {2'b00, m_c};
		sv_c = {nv_c[DW-1], nv_c} + {2'b00, m_c};

		side_c.face = face_c;
		side_c.mip  = mip_s1;
		side_c.szm1 = szm1_s1;
		side_c.nos  = nos_s1;
	end

	logic [DW-1:0] ru_s2, rv_s2, dvs_s2;
	side_t         side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (take2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take2 && v_s1) begin
			ru_s2   <= su_c[DW-1:0];
			rv_s2   <= sv_c[DW-1:0];
			dvs_s2  <= {m_c, 1'b0};
			side_s2 <= side_c;
		end
	end

	// ------------------------------------------------------------------
	// divider: u,v = floor((n + m) * 2^16 / 2m), one bit per stage
	// ------------------------------------------------------------------
	logic [UNIT_W-1:0] qu_d, qv_d;
	side_t             side_d;

	cbm_div #(
		.DIR_BITS (DIR_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.in_rem_u  (ru_s2),
		.in_rem_v  (rv_s2),
		.in_dvs    (dvs_s2),
		.in_side   (side_s2),
		.out_valid (div_out_valid),
		.out_ready (take3),
		.out_quo_u (qu_d),
		.out_quo_v (qv_d),
		.out_side  (side_d)
	);

	// ------------------------------------------------------------------
	// stage 3: scale by mip size minus one
	// ------------------------------------------------------------------
	logic [PW-1:0] pu_s3, pv_s3;
	side_t         side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (take3) begin
			v_s3 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take3 && div_out_valid) begin
			pu_s3   <= PW'(qu_d) * PW'(side_d.szm1);
			pv_s3   <= PW'(qv_d) * PW'(side_d.szm1);
			side_s3 <= side_d;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: corner texels clamped to the edge, blend fractions
	// ------------------------------------------------------------------
	logic [AW-1:0]        au_c, av_c, bu_c, bv_c, lim_c;
	logic [TEX_W-1:0]     x0_c, y0_c, x1_c, y1_c;
	logic [FRAC_BITS-1:0] fx_c, fy_c;

	always_comb begin
		lim_c = {1'b0, side_s3.szm1};
		au_c  = pu_s3[PW-1:UNIT_FRAC];
		av_c  = pv_s3[PW-1:UNIT_FRAC];
		bu_c  = au_c + 1'b1;
		bv_c  = av_c + 1'b1;
		x0_c  = (au_c > lim_c) ? side_s3.szm1 : au_c[TEX_W-1:0];
		y0_c  = (av_c > lim_c) ? side_s3.szm1 : av_c[TEX_W-1:0];
		x1_c  = (bu_c > lim_c) ? side_s3.szm1 : bu_c[TEX_W-1:0];
		y1_c  = (bv_c > lim_c) ? side_s3.szm1 : bv_c[TEX_W-1:0];
		fx_c  = pu_s3[UNIT_FRAC-1 -: FRAC_BITS];
		fy_c  = pv_s3[UNIT_FRAC-1 -: FRAC_BITS];
	end

	logic [FACE_W-1:0]    face_s4;
	logic [MIP_W-1:0]     mip_s4;
	logic [TEX_W-1:0]     x0_s4, y0_s4, x1_s4, y1_s4;
	logic [FRAC_BITS-1:0] fx_s4, fy_s4;
	logic                 nos_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (take4) begin
			v_s4 <= v_s3;
		end
	end

	// no sample: everything but the flag reads zero
	always_ff @(posedge clk) begin
		if (take4 && v_s3) begin
			nos_s4 <= side_s3.nos;
			if (side_s3.nos) begin
				face_s4 <= '0;
				mip_s4  <= '0;
				x0_s4   <= '0;
				y0_s4   <= '0;
				x1_s4   <= '0;
				y1_s4   <= '0;
				fx_s4   <= '0;
				fy_s4   <= '0;
			end else begin
				face_s4 <= side_s3.face;
				mip_s4  <= side_s3.mip;
				x0_s4   <= x0_c;
				y0_s4   <= y0_c;
				x1_s4   <= x1_c;
				y1_s4   <= y1_c;
				fx_s4   <= fx_c;
				fy_s4   <= fy_c;
			end
		end
	end

	assign out_valid = v_s4;
	assign face      = face_s4;
	assign mip_used  = mip_s4;
	assign texel_x0  = x0_s4;
	assign texel_y0  = y0_s4;
	assign texel_x1  = x1_s4;
	assign texel_y1  = y1_s4;
	assign frac_x    = fx_s4;
	assign frac_y    = fy_s4;
	assign no_sample = nos_s4;

endmodule

FILE: src/cbm_div.sv
// ---------------------------------------------------------------------------
// cbm_div
// two lockstep restoring dividers, one quotient bit per pipeline stage
// ---------------------------------------------------------------------------
module cbm_div #(
	parameter int DIR_BITS = cbm_pkg::DIR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [DIR_BITS:0]               in_rem_u,
	input  logic [DIR_BITS:0]               in_rem_v,
	input  logic [DIR_BITS:0]               in_dvs,
	input  cbm_pkg::side_t                  in_side,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cbm_pkg::UNIT_W-1:0]      out_quo_u,
	output logic [cbm_pkg::UNIT_W-1:0]      out_quo_v,
	output cbm_pkg::side_t                  out_side
);
	import cbm_pkg::*;

	localparam int DW  = DIR_BITS + 1;
	localparam int NST = UNIT_W;

	logic              vld_sd  [NST];
	logic [DW-1:0]     ru_sd   [NST];
	logic [DW-1:0]     rv_sd   [NST];
	logic [UNIT_W-1:0] qu_sd   [NST];
	logic [UNIT_W-1:0] qv_sd   [NST];
	logic [DW-1:0]     dvs_sd  [NST];
	side_t             side_sd [NST];
	logic              take    [NST];

	// one compare-subtract: trial value against divisor
	function automatic logic [DW:0] div_step(input logic [DW:0] t, input logic [DW-1:0] d);
		logic [DW:0] dd;
		logic [DW:0] r;
		dd = {1'b0, d};
		if (t >= dd) begin
			r = t - dd;
			div_step = {1'b1, r[DW-1:0]};
		end else begin
			div_step = {1'b0, t[DW-1:0]};
		end
	endfunction

	assign in_ready = take[0];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic          up_vld;
		logic [DW:0]   tu;
		logic [DW:0]   tv;
		logic [DW:0]   su;
		logic [DW:0]   sv;
		logic [DW-1:0] d_in;
		side_t         side_in;
		logic [UNIT_W-1:0] qu_in;
		logic [UNIT_W-1:0] qv_in;

		if (k == 0) begin : g_first
			// first bit: remainder starts at most equal to the divisor
			assign up_vld  = in_valid;
			assign tu      = {1'b0, in_rem_u};
			assign tv      = {1'b0, in_rem_v};
			assign d_in    = in_dvs;
			assign side_in = in_side;
			assign qu_in   = '0;
			assign qv_in   = '0;
		end else begin : g_next
			assign up_vld  = vld_sd[k-1];
			assign tu      = {ru_sd[k-1], 1'b0};
			assign tv      = {rv_sd[k-1], 1'b0};
			assign d_in    = dvs_sd[k-1];
			assign side_in = side_sd[k-1];
			assign qu_in   = qu_sd[k-1];
			assign qv_in   = qv_sd[k-1];
		end

		if (k == NST - 1) begin : g_last
			assign take[k] = !vld_sd[k] || out_ready;
		end else begin : g_mid
			assign take[k] = !vld_sd[k] || take[k+1];
		end

		assign su = div_step(tu, d_in);
		assign sv = div_step(tv, d_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (take[k]) begin
				vld_sd[k] <= up_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (take[k] && up_vld) begin
				ru_sd[k]   <= su[DW-1:0];
				rv_sd[k]   <= sv[DW-1:0];
				qu_sd[k]   <= {qu_in[UNIT_W-2:0], su[DW]};
				qv_sd[k]   <= {qv_in[UNIT_W-2:0], sv[DW]};
				dvs_sd[k]  <= d_in;
				side_sd[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_sd[NST-1];
	assign out_quo_u = qu_sd[NST-1];
	assign out_quo_v = qv_sd[NST-1];
	assign out_side  = side_sd[NST-1];

endmodule

FILE: src/cbm_checker.sv
// ---------------------------------------------------------------------------
// cbm_checker
// port-level checks on the address word stream
// ---------------------------------------------------------------------------
module cbm_checker #(
	parameter int FRAC_BITS = cbm_pkg::FRAC_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [cbm_pkg::FACE_W-1:0]  face,
	input logic [cbm_pkg::MIP_W-1:0]   mip_used,
	input logic [cbm_pkg::TEX_W-1:0]   texel_x0,
	input logic [cbm_pkg::TEX_W-1:0]   texel_y0,
	input logic [cbm_pkg::TEX_W-1:0]   texel_x1,
	input logic [cbm_pkg::TEX_W-1:0]   texel_y1,
	input logic [FRAC_BITS-1:0]        frac_x,
	input logic [FRAC_BITS-1:0]        frac_y,
	input logic                        no_sample
);
	import cbm_pkg::*;

	// a stalled word stays valid and holds its face, mip_used, x texels, frac_x and no_sample
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(face) && $stable(mip_used)
			&& $stable(texel_x0) && $stable(texel_x1) && $stable(frac_x)
			&& $stable(no_sample))
		else $error("output word changed while stalled");

	// no sample zeroes every other field
	a_nos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_sample |-> face == '0 && mip_used == '0 && texel_x0 == '0
			&& texel_y0 == '0 && texel_x1 == '0 && texel_y1 == '0
			&& frac_x == '0 && frac_y == '0)
		else $error("no sample word carries data");

	// second column is the first or the one after it
	a_x_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> texel_x1 >= texel_x0 && (texel_x1 - texel_x0) <= 1)
		else $error("texel_x1 not adjacent to texel_x0");

	// second row is the first or the one after it
	a_y_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> texel_y1 >= texel_y0 && (texel_y1 - texel_y0) <= 1)
		else $error("texel_y1 not adjacent to texel_y0");

endmodule

bind cubemap_bilinear_address_top cbm_checker #(
	.FRAC_BITS (FRAC_BITS)
) u_cbm_checker (.*);

FILE: tb/cbm_addr_checker.sv
// ---------------------------------------------------------------------------
// cbm_addr_checker
// watches the cube map address block and checks every address word
// ---------------------------------------------------------------------------
// Tracks the two registers from the write port, predicts one address word for
// each accepted direction word and compares results in order, field by field.
// ---------------------------------------------------------------------------
module cbm_addr_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbm_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic signed [15:0]               dir_x,
	input  logic signed [15:0]               dir_y,
	input  logic signed [15:0]               dir_z,
	input  logic [cbm_pkg::MIP_W-1:0]        mip_level,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [cbm_pkg::FACE_W-1:0]       face,
	input  logic [cbm_pkg::MIP_W-1:0]        mip_used,
	input  logic [cbm_pkg::TEX_W-1:0]        texel_x0,
	input  logic [cbm_pkg::TEX_W-1:0]        texel_y0,
	input  logic [cbm_pkg::TEX_W-1:0]        texel_x1,
	input  logic [cbm_pkg::TEX_W-1:0]        texel_y1,
	input  logic [7:0]                       frac_x,
	input  logic [7:0]                       frac_y,
	input  logic                             no_sample,
	output int                               mismatches,
	output int                               words_in_flight,
	output int                               words_checked,
	output int                               blank_words
);
	import cbm_pkg::*;

	localparam int FRAC_W = FRAC_BITS_DEF;

	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic [MIP_W-1:0]  mip;
		logic [TEX_W-1:0]  x0;
		logic [TEX_W-1:0]  y0;
		logic [TEX_W-1:0]  x1;
		logic [TEX_W-1:0]  y1;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic              blank;
	} addr_word_t;

	logic [FSIZE_W-1:0] cube_size;
	logic [MCNT_W-1:0]  mip_cnt;
	addr_word_t         expected_addrs[$];
	addr_word_t         want;

	// corner texels and blend weight along one axis of the face
	function automatic void split_axis(input int n, input int m, input int edge_len,
			output logic [TEX_W-1:0] c0, output logic [TEX_W-1:0] c1,
			output logic [FRAC_W-1:0] fr);
		longint unit_pos, p, a, b;
		unit_pos = (longint'(n + m) <<< 16) / (2 * longint'(m));
		if (unit_pos > 65536)
			unit_pos = 65536;
		p = unit_pos * (edge_len - 1);
		a = p >>> 16;
		b = a + 1;
		if (a > edge_len - 1)
			a = edge_len - 1;
		if (b > edge_len - 1)
			b = edge_len - 1;
		c0 = TEX_W'(a);
		c1 = TEX_W'(b);
		fr = FRAC_W'((p & 64'hFFFF) >> (16 - FRAC_W));
	endfunction

	function automatic addr_word_t address_for_direction(logic signed [15:0] dx,
			logic signed [15:0] dy, logic signed [15:0] dz, logic [MIP_W-1:0] lvl);
		addr_word_t w;
		int sx, sy, sz, ax, ay, az, major, nu, nv, top, mip, edge_len;
		w = '0;
		sx = dx;
		sy = dy;
		sz = dz;
		ax = sx < 0 ? -sx : sx;
		ay = sy < 0 ? -sy : sy;
		az = sz < 0 ? -sz : sz;
		if (cube_size == 0 || (ax == 0 && ay == 0 && az == 0)) begin
			w.blank = 1'b1;
			return w;
		end
		// largest axis wins, ties go to x then y
		if (ax >= ay && ax >= az) begin
			major = ax;
			nv = -sy;
			if (sx >= 0) begin
				w.face = FACE_PX;
				nu = -sz;
			end else begin
				w.face = FACE_NX;
				nu = sz;
			end
		end else if (ay >= az) begin
			major = ay;
			nu = sx;
			if (sy >= 0) begin
				w.face = FACE_PY;
				nv = sz;
			end else begin
				w.face = FACE_NY;
				nv = -sz;
			end
		end else begin
			major = az;
			nv = -sy;
			if (sz >= 0) begin
				w.face = FACE_PZ;
				nu = sx;
			end else begin
				w.face = FACE_NZ;
				nu = -sx;
			end
		end
		top = (mip_cnt == 0) ? 0 : int'(mip_cnt) - 1;
		mip = (int'(lvl) < top) ? int'(lvl) : top;
		edge_len = (cube_size > SIZE_LIMIT) ? int'(SIZE_LIMIT) : int'(cube_size);
		edge_len = edge_len >> mip;
		if (edge_len < 1)
			edge_len = 1;
		w.mip = MIP_W'(mip);
		split_axis(nu, major, edge_len, w.x0, w.x1, w.fx);
		split_axis(nv, major, edge_len, w.y0, w.y1, w.fy);
		return w;
	endfunction

	task automatic field_check(string fname, logic [15:0] exp_v, logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cube_size = FSIZE_RST;
			mip_cnt = MCNT_RST;
			expected_addrs.delete();
			mismatches = 0;
			words_in_flight = 0;
			words_checked = 0;
			blank_words = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_addrs.size() == 0) begin
					$display("%0t: unexpected address word, expected none, actual face %0d x0 %0d y0 %0d no_sample %0b",
						$time, face, texel_x0, texel_y0, no_sample);
					mismatches++;
				end else begin
					want = expected_addrs.pop_front();
					field_check("face", want.face, face);
					field_check("mip_used", want.mip, mip_used);
					field_check("texel_x0", want.x0, texel_x0);
					field_check("texel_y0", want.y0, texel_y0);
					field_check("texel_x1", want.x1, texel_x1);
					field_check("texel_y1", want.y1, texel_y1);
					field_check("frac_x", want.fx, frac_x);
					field_check("frac_y", want.fy, frac_y);
					field_check("no_sample", want.blank, no_sample);
					words_checked++;
					if (want.blank)
						blank_words++;
				end
			end
			if (in_valid && in_ready)
				expected_addrs.push_back(address_for_direction(dir_x, dir_y, dir_z, mip_level));
			if (cfg_we) begin
				case (cfg_index)
					REG_FACE_SIZE: cube_size = cfg_data;
					REG_MIP_COUNT: mip_cnt = cfg_data[MCNT_W-1:0];
					default: ;
				endcase
			end
			words_in_flight = expected_addrs.size();
		end
	end

endmodule

FILE: tb/tb_cubemap_bilinear_address_top.sv
// ---------------------------------------------------------------------------
// tb_cubemap_bilinear_address_top
// stimulus and verdict for the cube map bilinear address block
// ---------------------------------------------------------------------------
// Sends directed direction words (every face, ties, zero and most negative
// components, empty cube, oversized face, zero mip count) and then random
// words under several register settings, with random gaps on the input and
// random stalls on the output. The checker predicts and compares each word.
// ---------------------------------------------------------------------------
module tb_cubemap_bilinear_address_top;
	import cbm_pkg::*;

	localparam int LIMIT_CYCLES     = 200000;
	localparam int TAIL_CYCLES      = 40;
	localparam int WORDS_PER_SETTING = 80;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [15:0]       dir_x = '0;
	logic signed [15:0]       dir_y = '0;
	logic signed [15:0]       dir_z = '0;
	logic [MIP_W-1:0]         mip_level = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [FACE_W-1:0]        face;
	logic [MIP_W-1:0]         mip_used;
	logic [TEX_W-1:0]         texel_x0;
	logic [TEX_W-1:0]         texel_y0;
	logic [TEX_W-1:0]         texel_x1;
	logic [TEX_W-1:0]         texel_y1;
	logic [7:0]               frac_x;
	logic [7:0]               frac_y;
	logic                     no_sample;

	int mismatches;
	int words_in_flight;
	int words_checked;
	int blank_words;
	int cycles = 0;
	int settings_used = 0;
	bit no_gaps = 1'b0;   // set for the stretch with no idling on either side

	cubemap_bilinear_address_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.mip_level (mip_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.face      (face),
		.mip_used  (mip_used),
		.texel_x0  (texel_x0),
		.texel_y0  (texel_y0),
		.texel_x1  (texel_x1),
		.texel_y1  (texel_y1),
		.frac_x    (frac_x),
		.frac_y    (frac_y),
		.no_sample (no_sample)
	);

	cbm_addr_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.dir_x           (dir_x),
		.dir_y           (dir_y),
		.dir_z           (dir_z),
		.mip_level       (mip_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.face            (face),
		.mip_used        (mip_used),
		.texel_x0        (texel_x0),
		.texel_y0        (texel_y0),
		.texel_x1        (texel_x1),
		.texel_y1        (texel_y1),
		.frac_x          (frac_x),
		.frac_y          (frac_y),
		.no_sample       (no_sample),
		.mismatches      (mismatches),
		.words_in_flight (words_in_flight),
		.words_checked   (words_checked),
		.blank_words     (blank_words)
	);

	always #4 clk = ~clk;

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d words still expected",
				$time, cycles, words_in_flight);
			$display("cubemap_bilinear_address_top test failed");
			$finish;
		end
	end

	// output side stalls about 18 percent of the time
	always @(negedge clk)
		out_ready = no_gaps || ($urandom_range(99) >= 18);

	// hold valid until the word is taken, with random gaps before it
	task automatic send_word(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z, input logic [MIP_W-1:0] lvl);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 18) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		dir_x = x;
		dir_y = y;
		dir_z = z;
		mip_level = lvl;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// sender pauses until every expected word has come back
	task automatic drain_pipe();
		@(negedge clk);
		in_valid = 1'b0;
		while (words_in_flight != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// registers only change with the pipe empty
	task automatic set_cube(input logic [FSIZE_W-1:0] fsize, input logic [MCNT_W-1:0] mcnt);
		drain_pipe();
		write_reg(REG_FACE_SIZE, fsize);
		write_reg(REG_MIP_COUNT, CFG_W'(mcnt));
		settings_used++;
	endtask

	// mostly full-range values, with extremes and small values mixed in
	function automatic logic signed [15:0] pick_component();
		case ($urandom_range(9))
			0: return '0;
			1: return 16'sh8000;
			2: return 16'sh7FFF;
			3: return 16'($urandom_range(15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_word();
		logic signed [15:0] cx, cy, cz;
		cx = pick_component();
		cy = pick_component();
		cz = pick_component();
		// force magnitude ties now and then, and a zero direction rarely
		case ($urandom_range(19))
			0: begin
				cx = '0;
				cy = '0;
				cz = '0;
			end
			1: cy = cx;
			2: cz = -cy;
			3: cz = $urandom_range(1) ? cx : -cx;
			default: ;
		endcase
		send_word(cx, cy, cz, MIP_W'($urandom_range(15)));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: 256 texel face, one mip
		send_word(16'sd16384, 16'sd0, 16'sd0, 4'd0);
		send_word(-16'sd16384, 16'sd0, 16'sd0, 4'd0);
		send_word(16'sd0, 16'sd16384, 16'sd0, 4'd0);
		send_word(16'sd0, -16'sd16384, 16'sd0, 4'd0);
		send_word(16'sd0, 16'sd0, 16'sd16384, 4'd0);
		send_word(16'sd0, 16'sd0, -16'sd16384, 4'd0);
		// zero direction gives no sample
		send_word(16'sd0, 16'sd0, 16'sd0, 4'd0);
		// most negative components and magnitude ties
		send_word(16'sh8000, 16'sh7FFF, 16'sh8000, 4'd0);
		send_word(16'sh8000, 16'sh8000, 16'sh8000, 4'd15);
		send_word(16'sh7FFF, 16'sh7FFF, 16'sd1000, 4'd0);
		send_word(16'sd100, 16'sh8000, 16'sh8000, 4'd0);
		send_word(16'sh7FFF, -16'sh7FFF, 16'sh7FFF, 4'd0);
		// tiny directions
		send_word(16'sd1, 16'sd0, 16'sd0, 4'd0);
		send_word(16'sd0, 16'sd0, -16'sd1, 4'd0);
		send_word(-16'sd1, -16'sd1, -16'sd1, 4'd0);
		send_word(16'sd12345, -16'sd23456, 16'sd31000, 4'd15);

		// zero mip count acts as one, oversized face saturates
		set_cube(12'd4095, 4'd0);
		send_word(16'sd5000, -16'sd7000, -16'sd30000, 4'd15);
		send_word(16'sh8000, 16'sd0, 16'sd0, 4'd0);
		send_word(16'sh7FFF, 16'sh8000, 16'sh7FFF, 4'd3);

		// empty cube gives no sample whatever the direction
		set_cube(12'd0, 4'd1);
		send_word(16'sd16384, 16'sd16384, 16'sd16384, 4'd0);
		send_word(16'sh8000, 16'sh8000, 16'sh8000, 4'd15);

		// single texel face with a 12 level mip chain
		set_cube(12'd1, 4'd12);
		send_word(16'sd20000, -16'sd10000, 16'sd5000, 4'd11);
		send_word(-16'sd3, 16'sd2, 16'sd1, 4'd0);

		// random words under a spread of settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_cube(12'd2048, 4'd12);
				1: set_cube(12'd1, 4'd1);
				2: set_cube(12'd4095, 4'd15);
				3: set_cube(12'd700, 4'd5);
				default: set_cube(FSIZE_W'($urandom_range(4095)), MCNT_W'($urandom_range(15)));
			endcase
			no_gaps = (ph == 2);
			for (int k = 0; k < WORDS_PER_SETTING; k++)
				random_word();
			no_gaps = 1'b0;
		end

		drain_pipe();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d address words, %0d of them without a sample", words_checked,
			blank_words);
		$display("over %0d register settings, with every face, ties and input gaps and stalls",
			settings_used + 1);
		if (mismatches == 0 && words_in_flight == 0)
			$display("cubemap_bilinear_address_top test passed");
		else
			$display("cubemap_bilinear_address_top test failed");
		$finish;
	end

endmodule
